FILE: hw/rtl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants for the sweeping siren tone generator: field
// widths, command codes, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Field widths
  localparam int FREQ_W     = 15;
  localparam int TONE_W     = 20;
  localparam int LED_W      = 24;
  localparam int PERIOD_W   = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Default tick rate in Hz
  localparam int TICK_HZ_DEFAULT = 1000000;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_DUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_TOGGLE = 3'd4;

  // Register reset values
  localparam logic [FREQ_W-1:0] MIN_FREQ_RESET   = 15'd500;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RESET   = 15'd1500;
  localparam logic [FREQ_W-1:0] FREQ_STEP_RESET  = 15'd25;
  localparam logic [TONE_W-1:0] TONE_DUR_RESET   = 20'd20000;
  localparam logic [LED_W-1:0]  LED_TOGGLE_RESET = 24'd1000000;

  // Saturation limits
  localparam logic [FREQ_W-1:0]   HALF_MAX    = 15'h7FFF;
  localparam logic [PERIOD_W-1:0] PERIODS_MAX = 16'hFFFF;

  // Configuration register set
  typedef struct packed {
    logic [FREQ_W-1:0] freq_floor;
    logic [FREQ_W-1:0] freq_ceil;
    logic [FREQ_W-1:0] freq_incr;
    logic [TONE_W-1:0] tone_duration_us;
    logic [LED_W-1:0]  led_toggle_us;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic              buzzer_level;
    logic              red_led;
    logic              alarm_on;
    logic [FREQ_W-1:0] tone_freq_hz;
  } res_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_HALF,
    ST_DIV_COUNT,
    ST_EMIT
  } seq_state_t;

endpackage

FILE: hw/rtl/ssg_div.sv
// ----------------------------------------------------------------------------
// ssg_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle once the quotient is ready.
// ----------------------------------------------------------------------------
module ssg_div import ssg_pkg::*; #(
  parameter int DW = 20,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [VW-1:0]    dsr;
  logic [VW:0]      trial;
  logic             fits;

  // trial subtract of the next partial remainder
  assign trial = {rem, quo[DW-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[VW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/ssg_seq.sv
// ----------------------------------------------------------------------------
// ssg_seq
// Alarm sequencer: holds the siren state, runs the segment-start divisions
// (up to two) on the shared divider and applies one tick of wave advance.
// ----------------------------------------------------------------------------
module ssg_seq import ssg_pkg::*; #(
  parameter int TICK_HZ = TICK_HZ_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  input  logic             occupied,
  output logic             in_stall,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int TICK_W = $clog2(TICK_HZ + 1);
  localparam int DIV_W  = (TICK_W > TONE_W) ? TICK_W : TONE_W;

  seq_state_t state, state_next;

  logic                active_flag;
  logic                flash_flag;
  logic                led_lit;
  logic [FREQ_W-1:0]   sweep_freq;
  logic                sweep_up;
  logic [FREQ_W-1:0]   half_period_ticks;
  logic [PERIOD_W-1:0] periods_left;
  logic [FREQ_W-1:0]   phase_ticks;
  logic                wave_level;
  logic [LED_W-1:0]    led_wait;
  logic                advance;

  logic                in_fire;
  logic                seg_start;
  logic [LED_W-1:0]    led_wait_dec;
  logic [FREQ_W-1:0]   half_sat;
  logic [PERIOD_W-1:0] periods_sat;
  logic [FREQ_W:0]     phase_inc;
  logic [FREQ_W:0]     up_sum;
  logic [FREQ_W-1:0]   step_freq;
  logic                step_up;

  logic                div_start;
  logic                div_done;
  logic [DIV_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic [DIV_W-1:0]    div_quotient;

  ssg_div #(
    .DW (DIV_W),
    .VW (PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // input is taken only while the sequencer is idle
  assign in_stall = (state != ST_IDLE);

  // input transfer and segment start detect
  assign in_fire   = in_valid && !in_stall;
  assign seg_start = in_fire && (command == CMD_TICK) && active_flag &&
                     (periods_left == '0);

  assign led_wait_dec = (led_wait != '0) ? led_wait - LED_W'(1) : '0;

  // saturate the divider results
  always_comb begin
    if (div_quotient > DIV_W'(HALF_MAX)) begin
      half_sat = HALF_MAX;
    end else if (div_quotient == '0) begin
      half_sat = FREQ_W'(1);
    end else begin
      half_sat = div_quotient[FREQ_W-1:0];
    end
    if (div_quotient > DIV_W'(PERIODS_MAX)) begin
      periods_sat = PERIODS_MAX;
    end else begin
      periods_sat = div_quotient[PERIOD_W-1:0];
    end
  end

  // sweep step: saturate at the bounds and reverse direction
  assign up_sum = {1'b0, sweep_freq} + {1'b0, cfg.freq_incr};

  always_comb begin
    step_freq = sweep_freq;
    step_up   = sweep_up;
    if (sweep_up) begin
      if (up_sum >= {1'b0, cfg.freq_ceil}) begin
        step_freq = cfg.freq_ceil;
        step_up   = 1'b0;
      end else begin
        step_freq = up_sum[FREQ_W-1:0];
      end
    end else begin
      if ({1'b0, sweep_freq} <= ({1'b0, cfg.freq_floor} + {1'b0, cfg.freq_incr})) begin
        step_freq = cfg.freq_floor;
        step_up   = 1'b1;
      end else begin
        step_freq = sweep_freq - cfg.freq_incr;
      end
    end
  end

  assign phase_inc = {1'b0, phase_ticks} + (FREQ_W + 1)'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (seg_start) begin
            state_next = (sweep_freq != '0) ? ST_DIV_HALF : ST_DIV_COUNT;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV_HALF: begin
        if (div_done) state_next = ST_DIV_COUNT;
      end
      ST_DIV_COUNT: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and divider operand select
  always_comb begin
    res_valid    = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(cfg.tone_duration_us);
    div_divisor  = {half_sat, 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (seg_start) begin
          div_start = 1'b1;
          if (sweep_freq != '0) begin
            div_dividend = DIV_W'(TICK_HZ);
            div_divisor  = {sweep_freq, 1'b0};
          end else begin
            div_divisor = {HALF_MAX, 1'b0};
          end
        end
      end
      ST_DIV_HALF: begin
        div_start = div_done;
      end
      ST_DIV_COUNT: begin
      end
      ST_EMIT: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result shows the state before this tick's wave advance
  always_comb begin
    res.buzzer_level = wave_level;
    res.red_led      = led_lit;
    res.alarm_on     = active_flag;
    res.tone_freq_hz = active_flag ? sweep_freq : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      active_flag       <= 1'b0;
      flash_flag        <= 1'b0;
      led_lit           <= 1'b0;
      sweep_freq        <= MIN_FREQ_RESET;
      sweep_up          <= 1'b1;
      half_period_ticks <= '0;
      periods_left      <= '0;
      phase_ticks       <= '0;
      wave_level        <= 1'b0;
      led_wait          <= '0;
      advance           <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            advance <= (command == CMD_TICK) && active_flag;
            case (command)
              CMD_TRIGGER: begin
                if (!active_flag) begin
                  active_flag       <= 1'b1;
                  flash_flag        <= occupied;
                  led_lit           <= 1'b0;
                  sweep_freq        <= cfg.freq_floor;
                  sweep_up          <= 1'b1;
                  half_period_ticks <= '0;
                  periods_left      <= '0;
                  phase_ticks       <= '0;
                  wave_level        <= 1'b0;
                  led_wait          <= '0;
                end
              end
              CMD_STOP: begin
                if (active_flag) begin
                  active_flag       <= 1'b0;
                  flash_flag        <= 1'b0;
                  led_lit           <= 1'b0;
                  sweep_freq        <= cfg.freq_floor;
                  sweep_up          <= 1'b1;
                  half_period_ticks <= '0;
                  periods_left      <= '0;
                  phase_ticks       <= '0;
                  wave_level        <= 1'b0;
                  led_wait          <= '0;
                end
              end
              CMD_TICK: begin
                if (active_flag) begin
                  // LED interval restarts when the LED toggles
                  if ((periods_left == '0) && flash_flag && (led_wait_dec == '0)) begin
                    led_wait <= cfg.led_toggle_us;
                  end else begin
                    led_wait <= led_wait_dec;
                  end
                  if (periods_left == '0) begin
                    // LED flashing at segment start
                    if (flash_flag) begin
                      if (led_wait_dec == '0) begin
                        led_lit <= !led_lit;
                      end
                    end else begin
                      led_lit <= 1'b0;
                    end
                    // zero frequency skips the first division
                    if (sweep_freq == '0) begin
                      half_period_ticks <= HALF_MAX;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV_HALF: begin
          if (div_done) half_period_ticks <= half_sat;
        end
        ST_DIV_COUNT: begin
          if (div_done) begin
            periods_left <= periods_sat;
            phase_ticks  <= '0;
            wave_level   <= (periods_sat != '0);
          end
        end
        ST_EMIT: begin
          // one tick of square wave advance
          if (res_ready && advance) begin
            if (periods_left == '0) begin
              wave_level <= 1'b0;
              sweep_freq <= step_freq;
              sweep_up   <= step_up;
            end else if (phase_inc >= {1'b0, half_period_ticks}) begin
              phase_ticks <= '0;
              if (wave_level) begin
                wave_level <= 1'b0;
              end else begin
                periods_left <= periods_left - PERIOD_W'(1);
                if (periods_left == PERIOD_W'(1)) begin
                  sweep_freq <= step_freq;
                  sweep_up   <= step_up;
                end else begin
                  wave_level <= 1'b1;
                end
              end
            end else begin
              phase_ticks <= phase_inc[FREQ_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sweeping_siren_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// sweeping_siren_tone_generator_unit
// Triangle-sweep siren: square wave buzzer drive with optional LED flashing.
// ----------------------------------------------------------------------------
// One input item is one tick (or a trigger or stop) and yields one result.
// A plain tick, trigger or stop passes through the emit state into the
// output register. A tick that opens a new tone segment runs up to two
// divisions on one shared radix-2 divider (half period, unless the frequency
// is zero, then period count) of width W = max(20, bits of TICK_HZ). The
// input is stalled while an item is in work; a finished result sits in the
// output register, so the next transfer can be taken while it waits.
// Configuration writes are taken on every cycle and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module sweeping_siren_tone_generator_unit import ssg_pkg::*; #(
  parameter int TICK_HZ = TICK_HZ_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic                  occupied,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  buzzer_level,
  output logic                  red_led,
  output logic                  alarm_on,
  output logic [FREQ_W-1:0]     tone_freq_hz
);

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_floor       <= MIN_FREQ_RESET;
      cfg.freq_ceil        <= MAX_FREQ_RESET;
      cfg.freq_incr        <= FREQ_STEP_RESET;
      cfg.tone_duration_us <= TONE_DUR_RESET;
      cfg.led_toggle_us    <= LED_TOGGLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_FREQ:   cfg.freq_floor       <= cfg_data[FREQ_W-1:0];
        REG_MAX_FREQ:   cfg.freq_ceil        <= cfg_data[FREQ_W-1:0];
        REG_FREQ_STEP:  cfg.freq_incr        <= cfg_data[FREQ_W-1:0];
        REG_TONE_DUR:   cfg.tone_duration_us <= cfg_data[TONE_W-1:0];
        REG_LED_TOGGLE: cfg.led_toggle_us    <= cfg_data[LED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssg_seq #(
    .TICK_HZ (TICK_HZ)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .command   (command),
    .occupied  (occupied),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      buzzer_level <= res.buzzer_level;
      red_led      <= res.red_led;
      alarm_on     <= res.alarm_on;
      tone_freq_hz <= res.tone_freq_hz;
    end
  end

endmodule
